// File: rtl/fct_pkg.sv
// fct_pkg: shared constants, codes and types of the frustum cull test
`default_nettype none
package fct_pkg;

  // coordinate width (Q16.4, signed) and number of planes tested
  localparam int COORD_BITS  = 20;
  localparam int PLANE_COUNT = 6;

  // sizes (radius, half-extents, tolerance) are unsigned, one bit narrower
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int NORM_BITS  = 14;
  localparam int OFFS_BITS  = 22;
  localparam int FRAC_SHIFT = 12;

  // operand after corner pick, one product, distance sum, threshold
  localparam int OP_W      = COORD_BITS + 1;
  localparam int PROD_W    = NORM_BITS + OP_W;
  localparam int DIST_BASE = (PROD_W > OFFS_BITS + FRAC_SHIFT) ? PROD_W
                                                                : OFFS_BITS + FRAC_SHIFT;
  localparam int DIST_W    = DIST_BASE + 2;
  localparam int THR_W     = SIZE_BITS + 1;

  // plane register packing
  localparam int PLANE_W = 64;
  localparam int NX_LSB  = 0;
  localparam int NY_LSB  = 14;
  localparam int NZ_LSB  = 28;
  localparam int D_LSB   = 42;

  // configuration register map
  localparam int CFG_DATA_W  = PLANE_W;
  localparam int CFG_IDX_W   = 3;
  localparam int PLANE_REGS  = 6;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd6;
  localparam logic [SIZE_BITS-1:0] TOL_RESET     = SIZE_BITS'(8);

  // shape codes
  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_SPHERE = 2'd1;
  localparam logic [1:0] KIND_BOX    = 2'd2;

  typedef logic [PLANE_W-1:0] plane_t;

  // three normal-by-coordinate products of one plane
  typedef struct packed {
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;
    logic signed [PROD_W-1:0] pz;
  } fct_prod_t;

endpackage
`default_nettype wire

// File: rtl/fct_in_if.sv
// fct_in_if: query channel carrying one shape per item
`default_nettype none
interface fct_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           kind;
  logic signed [fct_pkg::COORD_BITS-1:0] pos_x;
  logic signed [fct_pkg::COORD_BITS-1:0] pos_y;
  logic signed [fct_pkg::COORD_BITS-1:0] pos_z;
  logic [fct_pkg::SIZE_BITS-1:0]        radius;
  logic [fct_pkg::SIZE_BITS-1:0]        half_x;
  logic [fct_pkg::SIZE_BITS-1:0]        half_y;
  logic [fct_pkg::SIZE_BITS-1:0]        half_z;

  modport source (output valid, kind, pos_x, pos_y, pos_z, radius, half_x, half_y, half_z,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, radius, half_x, half_y, half_z,
                output ready);
endinterface
`default_nettype wire

// File: rtl/fct_out_if.sv
// fct_out_if: result channel carrying one visible flag per item
`default_nettype none
interface fct_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface
`default_nettype wire

// File: rtl/fct_plane_mul.sv
// fct_plane_mul: corner pick and registered normal products for one plane
`default_nettype none
module fct_plane_mul (
  input  wire logic                                  clk_i,
  input  wire logic                                  en_i,
  input  wire fct_pkg::plane_t                       plane_i,
  input  wire logic [1:0]                            kind_i,
  input  wire logic signed [fct_pkg::COORD_BITS-1:0] pos_x_i,
  input  wire logic signed [fct_pkg::COORD_BITS-1:0] pos_y_i,
  input  wire logic signed [fct_pkg::COORD_BITS-1:0] pos_z_i,
  input  wire logic [fct_pkg::SIZE_BITS-1:0]         half_x_i,
  input  wire logic [fct_pkg::SIZE_BITS-1:0]         half_y_i,
  input  wire logic [fct_pkg::SIZE_BITS-1:0]         half_z_i,
  output fct_pkg::fct_prod_t                         prod_o
);

  // box: near corner by normal sign, otherwise the position itself
  function automatic logic signed [fct_pkg::OP_W-1:0] pick_op(
    input logic [1:0]                            kind,
    input logic signed [fct_pkg::NORM_BITS-1:0]  n,
    input logic signed [fct_pkg::COORD_BITS-1:0] c,
    input logic [fct_pkg::SIZE_BITS-1:0]         h
  );
    logic signed [fct_pkg::OP_W-1:0] c_ext;
    logic signed [fct_pkg::OP_W-1:0] h_ext;
    logic                            n_pos;
    c_ext = {c[fct_pkg::COORD_BITS-1], c};
    h_ext = {2'b00, h};
    n_pos = !n[fct_pkg::NORM_BITS-1] && (|n);
    if (kind == fct_pkg::KIND_BOX) begin
      pick_op = n_pos ? (c_ext - h_ext) : (c_ext + h_ext);
    end else begin
      pick_op = c_ext;
    end
  endfunction

  // signed product, both operands widened to the product width
  function automatic logic signed [fct_pkg::PROD_W-1:0] mul(
    input logic signed [fct_pkg::NORM_BITS-1:0] n,
    input logic signed [fct_pkg::OP_W-1:0]      op
  );
    logic signed [fct_pkg::PROD_W-1:0] n_ext;
    logic signed [fct_pkg::PROD_W-1:0] op_ext;
    n_ext  = {{(fct_pkg::PROD_W - fct_pkg::NORM_BITS){n[fct_pkg::NORM_BITS-1]}}, n};
    op_ext = {{(fct_pkg::PROD_W - fct_pkg::OP_W){op[fct_pkg::OP_W-1]}}, op};
    mul    = n_ext * op_ext;
  endfunction

  logic signed [fct_pkg::NORM_BITS-1:0] nx, ny, nz;
  fct_pkg::fct_prod_t                   prod_d;
  fct_pkg::fct_prod_t                   prod_q;

  assign nx = plane_i[fct_pkg::NX_LSB +: fct_pkg::NORM_BITS];
  assign ny = plane_i[fct_pkg::NY_LSB +: fct_pkg::NORM_BITS];
  assign nz = plane_i[fct_pkg::NZ_LSB +: fct_pkg::NORM_BITS];

  // per-axis products
  always_comb begin
    prod_d.px = mul(nx, pick_op(kind_i, nx, pos_x_i, half_x_i));
    prod_d.py = mul(ny, pick_op(kind_i, ny, pos_y_i, half_y_i));
    prod_d.pz = mul(nz, pick_op(kind_i, nz, pos_z_i, half_z_i));
  end

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// File: rtl/fct_plane_cmp.sv
// fct_plane_cmp: distance sum and reject decision for one plane
`default_nettype none
module fct_plane_cmp (
  input  wire fct_pkg::fct_prod_t                   prod_i,
  input  wire logic signed [fct_pkg::OFFS_BITS-1:0] offs_i,
  input  wire logic [1:0]                           kind_i,
  input  wire logic [fct_pkg::THR_W-1:0]            thr_i,
  output logic                                      reject_o
);

  localparam int PX = fct_pkg::DIST_W - fct_pkg::PROD_W;
  localparam int DX = fct_pkg::DIST_W - fct_pkg::OFFS_BITS - fct_pkg::FRAC_SHIFT;
  localparam int TX = fct_pkg::DIST_W - fct_pkg::THR_W - fct_pkg::FRAC_SHIFT;

  logic signed [fct_pkg::DIST_W-1:0] dist_sum;
  logic signed [fct_pkg::DIST_W-1:0] thr_s;

  // signed distance on the 1/65536 grid
  assign dist_sum = $signed({{PX{prod_i.px[fct_pkg::PROD_W-1]}}, prod_i.px})
                  + $signed({{PX{prod_i.py[fct_pkg::PROD_W-1]}}, prod_i.py})
                  + $signed({{PX{prod_i.pz[fct_pkg::PROD_W-1]}}, prod_i.pz})
                  + $signed({{DX{offs_i[fct_pkg::OFFS_BITS-1]}}, offs_i,
                             {fct_pkg::FRAC_SHIFT{1'b0}}});

  // threshold scaled to the same grid
  assign thr_s = $signed({{TX{1'b0}}, thr_i, {fct_pkg::FRAC_SHIFT{1'b0}}});

  // compare by shape
  always_comb begin
    case (kind_i)
      fct_pkg::KIND_POINT,
      fct_pkg::KIND_SPHERE: reject_o = (dist_sum > thr_s);
      fct_pkg::KIND_BOX:    reject_o = (dist_sum > $signed({fct_pkg::DIST_W{1'b0}}));
      default:              reject_o = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/frustum_cull_test.sv
// frustum_cull_test: top level of the frustum visibility test
// Usage:
//   in_i carries one query item per handshake: a shape code (point, sphere,
//   axis-aligned box), a Q16.4 position and the sphere radius or box
//   half-extents. out_o returns one item per query holding the visible flag.
//   Items leave in the order they arrive.
//   Six planes and the tolerance are loaded through cfg_we_i / cfg_idx_i /
//   cfg_data_i while no query is in flight; index 6 is the tolerance and
//   indexes above it are ignored.
//   Pipeline: input register, product register (three multipliers per
//   plane), result register, in that order. One item per cycle is
//   sustained while out_o.ready stays high, set by the product stage of
//   all planes working in parallel.
//   Reset clears the pipeline, zeroes the planes and sets the tolerance
//   to 0.5. When out_o is stalled the stages fill up behind it; in_i.ready
//   falls only once all three stages hold items, so nothing is lost.
`default_nettype none
module frustum_cull_test (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [fct_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [fct_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  fct_in_if.sink                                in_i,
  fct_out_if.source                             out_o
);

  // configuration registers
  fct_pkg::plane_t               plane_q [fct_pkg::PLANE_REGS];
  logic [fct_pkg::SIZE_BITS-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fct_pkg::PLANE_REGS; i++) begin
        plane_q[i] <= '0;
      end
      tol_q <= fct_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fct_pkg::REG_TOLERANCE) begin
        tol_q <= cfg_data_i[fct_pkg::SIZE_BITS-1:0];
      end else if (32'(cfg_idx_i) < fct_pkg::PLANE_REGS) begin
        plane_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  // pipeline flow control
  logic s0_v_q, s1_v_q, out_v_q;
  logic out_free, s1_free, s0_free;

  assign out_free   = !out_v_q || out_o.ready;
  assign s1_free    = !s1_v_q || out_free;
  assign s0_free    = !s0_v_q || s1_free;
  assign in_i.ready = s0_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s0_free)  s0_v_q  <= in_i.valid;
      if (s1_free)  s1_v_q  <= s0_v_q;
      if (out_free) out_v_q <= s1_v_q;
    end
  end

  // input register
  logic [1:0]                            s0_kind_q;
  logic signed [fct_pkg::COORD_BITS-1:0] s0_px_q, s0_py_q, s0_pz_q;
  logic [fct_pkg::SIZE_BITS-1:0]         s0_rad_q, s0_hx_q, s0_hy_q, s0_hz_q;

  always_ff @(posedge clk_i) begin
    if (s0_free) begin
      s0_kind_q <= in_i.kind;
      s0_px_q   <= in_i.pos_x;
      s0_py_q   <= in_i.pos_y;
      s0_pz_q   <= in_i.pos_z;
      s0_rad_q  <= in_i.radius;
      s0_hx_q   <= in_i.half_x;
      s0_hy_q   <= in_i.half_y;
      s0_hz_q   <= in_i.half_z;
    end
  end

  // threshold: radius plus tolerance for a sphere, tolerance alone otherwise
  logic [fct_pkg::THR_W-1:0] thr_d;
  logic [fct_pkg::THR_W-1:0] s1_thr_q;
  logic [1:0]                s1_kind_q;

  always_comb begin
    if (s0_kind_q == fct_pkg::KIND_SPHERE) begin
      thr_d = {1'b0, s0_rad_q} + {1'b0, tol_q};
    end else begin
      thr_d = {1'b0, tol_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_kind_q <= s0_kind_q;
      s1_thr_q  <= thr_d;
    end
  end

  // per-plane products and reject decisions
  logic [fct_pkg::PLANE_COUNT-1:0] reject;

  for (genvar g = 0; g < fct_pkg::PLANE_COUNT; g++) begin : g_plane
    fct_pkg::fct_prod_t prod;

    fct_plane_mul u_mul (
      .clk_i    (clk_i),
      .en_i     (s1_free),
      .plane_i  (plane_q[g]),
      .kind_i   (s0_kind_q),
      .pos_x_i  (s0_px_q),
      .pos_y_i  (s0_py_q),
      .pos_z_i  (s0_pz_q),
      .half_x_i (s0_hx_q),
      .half_y_i (s0_hy_q),
      .half_z_i (s0_hz_q),
      .prod_o   (prod)
    );

    fct_plane_cmp u_cmp (
      .prod_i   (prod),
      .offs_i   (plane_q[g][fct_pkg::D_LSB +: fct_pkg::OFFS_BITS]),
      .kind_i   (s1_kind_q),
      .thr_i    (s1_thr_q),
      .reject_o (reject[g])
    );
  end

  // result register
  logic vis_q;

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      vis_q <= ~(|reject);
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.visible = vis_q;

`ifndef SYNTHESIS
  // an accepted item lands in the input register
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s0_v_q)
    else $error("accepted item not held in input stage");

  // a blocked input stage keeps its item
  a_s0_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_v_q && !s1_free) |=> (s0_v_q && $stable(s0_kind_q) && $stable(s0_px_q)))
    else $error("input stage item dropped while blocked");

  // a blocked product stage keeps its item
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !out_free) |=> (s1_v_q && $stable(s1_kind_q) && $stable(s1_thr_q)))
    else $error("product stage item dropped while blocked");

  // an unused shape code always comes out visible
  a_unused_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_free && s1_kind_q != fct_pkg::KIND_POINT
     && s1_kind_q != fct_pkg::KIND_SPHERE && s1_kind_q != fct_pkg::KIND_BOX)
    |=> (out_v_q && vis_q))
    else $error("unused shape code reported not visible");
`endif

endmodule
`default_nettype wire
